>>> design/assert_macros.svh
// assertion macros used by the decoder back end
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define B64D_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("b64d assertion failed");

// condition must never be seen outside reset
`define B64D_ASSERT_NEVER(lbl, clk, rstn, cond) \
  `B64D_ASSERT(lbl, clk, rstn, !(cond))

`endif

>>> design/b64d_pkg.sv
// shared types, constants and the alphabet lookup of the base64 decoder
`default_nettype none
package b64d_pkg;

  localparam int unsigned FifoDepth = 4;  // power of two
  localparam int unsigned FifoAw    = $clog2(FifoDepth);
  localparam int unsigned FifoCw    = $clog2(FifoDepth + 1);
  localparam int unsigned MaxRes    = 3;

  // classified item handed from front to back
  typedef struct packed {
    logic       last;
    logic       good;
    logic [5:0] value;
  } entry_t;

  // one result item
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        byte_valid;
    logic [23:0] byte_count;
    logic        cap_reached;
    logic        msg_done;
  } res_t;

  // standard alphabet, bit 6 set for a character outside it
  function automatic logic [6:0] sym_value(input logic [7:0] c);
    logic [6:0] r;
    r = 7'h40;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = {1'b0, 6'(c - 8'h41)};
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      r = {1'b0, 6'(c - 8'h61 + 8'd26)};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, 6'(c - 8'h30 + 8'd52)};
    end else if (c == 8'h2b) begin
      r = {1'b0, 6'd62};
    end else if (c == 8'h2f) begin
      r = {1'b0, 6'd63};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> design/b64d_front.sv
// front end: accepts input items, classifies characters, drops idle items
`default_nettype none
module b64d_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [7:0]      in_sym_i,
  input  wire logic            in_sym_valid_i,
  input  wire logic            in_last_i,
  output logic                 ent_valid_o,
  output b64d_pkg::entry_t     ent_o,
  input  wire logic            ent_ready_i
);

  logic             vld_q, vld_d;
  b64d_pkg::entry_t ent_q, ent_d;
  logic [6:0]       lookup;
  logic             keep;

  assign lookup     = b64d_pkg::sym_value(in_sym_i);
  assign in_ready_o = !vld_q || ent_ready_i;

  always_comb begin
    ent_d.last  = in_last_i;
    ent_d.good  = in_sym_valid_i && !lookup[6];
    ent_d.value = lookup[5:0];
    // an item with no character and no end mark changes nothing
    keep  = ent_d.good || in_last_i;
    vld_d = vld_q;
    if (in_valid_i && in_ready_o) begin
      vld_d = keep;
    end else if (ent_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      ent_q <= ent_d;
    end
  end

  assign ent_valid_o = vld_q;
  assign ent_o       = ent_q;

endmodule
`default_nettype wire

>>> design/b64d_fifo.sv
// short queue of classified items between front and back
`default_nettype none
module b64d_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_valid_i,
  output logic                   push_ready_o,
  input  wire b64d_pkg::entry_t  push_ent_i,
  output logic                   pop_valid_o,
  input  wire logic              pop_i,
  output b64d_pkg::entry_t       pop_ent_o
);

  b64d_pkg::entry_t                 mem_q [b64d_pkg::FifoDepth];
  logic [b64d_pkg::FifoAw-1:0]      wr_q, wr_d, rd_q, rd_d;
  logic [b64d_pkg::FifoCw-1:0]      cnt_q, cnt_d;
  logic                             do_push, do_pop;

  assign push_ready_o = (cnt_q != b64d_pkg::FifoCw'(b64d_pkg::FifoDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign pop_ent_o    = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_ent_i;
    end
  end

endmodule
`default_nettype wire

>>> design/b64d_back.sv
// back end: sextet packing, capacity limit and the result buffer
`default_nettype none
`include "assert_macros.svh"
module b64d_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [23:0]       cap_i,
  input  wire logic              ent_valid_i,
  input  wire b64d_pkg::entry_t  ent_i,
  output logic                   ent_pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output b64d_pkg::res_t         out_res_o
);

  logic [23:0]    acc_q, acc_d;
  logic [1:0]     cnt_q, cnt_d;
  logic [23:0]    emit_q, emit_d;
  logic           full_q, full_d;
  b64d_pkg::res_t res_q [b64d_pkg::MaxRes];
  b64d_pkg::res_t res_new [b64d_pkg::MaxRes];
  logic [1:0]     ptr_q, ptr_d, pend_q, pend_d;

  logic [24:0] diff;
  logic        d_small, full_now, sym_in, group, out_hs, load, reached_k;
  logic [1:0]  avail, want, k, n, cnt_new;
  logic [23:0] ins, acc_new;

  assign out_valid_o = (pend_q != 2'd0);
  assign out_res_o   = res_q[ptr_q];
  assign out_hs      = out_valid_o && out_ready_i;

  always_comb begin
    // room left under the capacity
    diff     = {1'b0, cap_i} - {1'b0, emit_q};
    d_small  = (diff[24:2] == 23'd0);
    full_now = full_q || diff[24] || (diff == 25'd0);
    if (full_now) begin
      avail = 2'd0;
    end else if (d_small) begin
      avail = diff[1:0];
    end else begin
      avail = 2'd3;
    end

    sym_in = ent_i.good && !full_now;
    unique case (cnt_q)
      2'd0: ins = {ent_i.value, 18'd0};
      2'd1: ins = {6'd0, ent_i.value, 12'd0};
      2'd2: ins = {12'd0, ent_i.value, 6'd0};
      2'd3: ins = {18'd0, ent_i.value};
      default: ins = '0;
    endcase
    acc_new = sym_in ? (acc_q | ins) : acc_q;
    cnt_new = sym_in ? cnt_q + 2'd1 : cnt_q;
    group   = sym_in && (cnt_q == 2'd3);

    // bytes asked for: a full group, or the leftover on the end mark
    if (group) begin
      want = 2'd3;
    end else if (ent_i.last && cnt_new[1]) begin
      want = cnt_new - 2'd1;
    end else begin
      want = 2'd0;
    end
    k = (want < avail) ? want : avail;
    reached_k = (k != 2'd0) && d_small && (diff[1:0] == k);

    for (int i = 0; i < b64d_pkg::MaxRes; i++) begin
      res_new[i].data_byte   = acc_new[23 - 8*i -: 8];
      res_new[i].byte_valid  = 1'b1;
      res_new[i].byte_count  = emit_q + 24'(i + 1);
      res_new[i].cap_reached = d_small && (diff[1:0] == 2'(i + 1));
      res_new[i].msg_done    = ent_i.last && (k == 2'(i + 1));
    end
    if (k == 2'd0) begin
      // closing item with no byte
      res_new[0].data_byte   = 8'd0;
      res_new[0].byte_valid  = 1'b0;
      res_new[0].byte_count  = emit_q;
      res_new[0].cap_reached = full_now;
      res_new[0].msg_done    = 1'b1;
      n = ent_i.last ? 2'd1 : 2'd0;
    end else begin
      n = k;
    end

    // items without results slip past a busy buffer
    ent_pop_o = ent_valid_i &&
                ((n == 2'd0) || (pend_q == 2'd0) || ((pend_q == 2'd1) && out_hs));
    load = ent_pop_o && (n != 2'd0);

    acc_d  = acc_q;
    cnt_d  = cnt_q;
    emit_d = emit_q;
    full_d = full_q;
    if (ent_pop_o) begin
      if (ent_i.last) begin
        acc_d  = '0;
        cnt_d  = '0;
        emit_d = '0;
        full_d = 1'b0;
      end else begin
        acc_d  = group ? 24'd0 : acc_new;
        cnt_d  = cnt_new;
        emit_d = emit_q + {22'd0, k};
        full_d = full_q || reached_k || (k < want);
      end
    end

    ptr_d  = ptr_q;
    pend_d = pend_q;
    if (load) begin
      ptr_d  = 2'd0;
      pend_d = n;
    end else if (out_hs) begin
      ptr_d  = ptr_q + 2'd1;
      pend_d = pend_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      cnt_q  <= '0;
      emit_q <= '0;
      full_q <= 1'b0;
      ptr_q  <= '0;
      pend_q <= '0;
    end else begin
      acc_q  <= acc_d;
      cnt_q  <= cnt_d;
      emit_q <= emit_d;
      full_q <= full_d;
      ptr_q  <= ptr_d;
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int i = 0; i < b64d_pkg::MaxRes; i++) begin
        res_q[i] <= res_new[i];
      end
    end
  end

  `B64D_ASSERT_NEVER(a_buf_bound, clk_i, rst_ni, ({1'b0, ptr_q} + {1'b0, pend_q}) > 3'd3)
  `B64D_ASSERT(a_done_last, clk_i, rst_ni, (out_valid_o && out_res_o.msg_done) |-> (pend_q == 2'd1))
  `B64D_ASSERT(a_empty_closes, clk_i, rst_ni, (out_valid_o && !out_res_o.byte_valid) |-> out_res_o.msg_done)

endmodule
`default_nettype wire

>>> design/base64_stream_decoder.sv
// top level of the streaming base64 decoder with its capacity register
//
//  channel   dir  handshake              payload
//  s_axis    in   tvalid/tready          tdata[7:0] symbol, tuser[0] symbol_valid,
//                                        tlast end_of_message
//  m_axis    out  tvalid/tready          tdata[7:0] data_byte, [31:8] byte_count,
//                                        [32] capacity_reached, tuser[0] byte_valid,
//                                        tlast message_done
//  apb       in   psel/penable/pready    0x0 output_capacity[23:0]
//
// one input item per cycle sustained on ordinary text while the output does not stall; the back
// end emits one result per cycle while m_axis_tready is high, from a three-entry result buffer,
// so the three bytes of a group of four symbols overlap the next symbols
// items that cause no result pass the back end even while results wait to leave
// the four-entry queue lets the front keep accepting while the output side stalls
// reset clears the queue, the packing state and sets the capacity to its maximum
`default_nettype none
module base64_stream_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // fields from bit 0: symbol
  input  wire logic [7:0]  s_axis_tdata,
  // fields from bit 0: symbol_valid
  input  wire logic [0:0]  s_axis_tuser,
  input  wire logic        s_axis_tlast,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // fields from bit 0: data_byte, byte_count, capacity_reached, zero fill
  output logic [39:0]      m_axis_tdata,
  // fields from bit 0: byte_valid
  output logic [0:0]       m_axis_tuser,
  output logic             m_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam logic [23:0] CapReset = 24'hffffff;

  logic [23:0]      cap_q, cap_d;
  logic             fr_valid, fr_ready, q_valid, q_pop;
  b64d_pkg::entry_t fr_ent, q_ent;
  b64d_pkg::res_t   res;

  // configuration port, register index taken from the word address
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {8'd0, cap_q} : 32'd0;

  always_comb begin
    cap_d = cap_q;
    if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      cap_d = pwdata[23:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else begin
      cap_q <= cap_d;
    end
  end

  // classify and drop idle items
  b64d_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .in_sym_i       (s_axis_tdata),
    .in_sym_valid_i (s_axis_tuser[0]),
    .in_last_i      (s_axis_tlast),
    .ent_valid_o    (fr_valid),
    .ent_o          (fr_ent),
    .ent_ready_i    (fr_ready)
  );

  // decouples the classifier from the packing back end
  b64d_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_ent_i   (fr_ent),
    .pop_valid_o  (q_valid),
    .pop_i        (q_pop),
    .pop_ent_o    (q_ent)
  );

  // packing, capacity limit and result buffer
  b64d_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cap_i       (cap_q),
    .ent_valid_i (q_valid),
    .ent_i       (q_ent),
    .ent_pop_o   (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res)
  );

  assign m_axis_tdata = {7'd0, res.cap_reached, res.byte_count, res.data_byte};
  assign m_axis_tuser = res.byte_valid;
  assign m_axis_tlast = res.msg_done;

endmodule
`default_nettype wire

>>> bench/b64d_checker.sv
// checker for the base64 stream decoder: decoding predictor and result comparison
`timescale 1ns / 1ps
module b64d_checker #(
  parameter logic [2:0] CapAddr = 3'd0
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  sym_tdata_i,
  input  logic [0:0]  sym_tuser_i,
  input  logic        sym_tlast_i,
  input  logic        sym_tvalid_i,
  input  logic        sym_tready_i,
  input  logic [39:0] byte_tdata_i,
  input  logic [0:0]  byte_tuser_i,
  input  logic        byte_tlast_i,
  input  logic        byte_tvalid_i,
  input  logic        byte_tready_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  output int          mismatch_count_o,
  output int          pending_count_o
);

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        byte_valid;
    logic [23:0] byte_count;
    logic        cap_reached;
    logic        msg_done;
  } dec_byte_t;

  localparam int NotInAlphabet = -1;

  logic [23:0] capacity = 24'hFFFFFF;
  logic [23:0] accum    = '0;
  logic [1:0]  sextets  = '0;
  logic [23:0] emitted  = '0;
  logic        full     = 1'b0;
  dec_byte_t   byte_q[$];
  dec_byte_t   run_bytes[3];
  int          run_len = 0;
  int          mismatches = 0;
  int          pending = 0;

  assign mismatch_count_o = mismatches;
  assign pending_count_o  = pending;

  function automatic int sextet_of(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return int'(c - "A");
    if (c >= "a" && c <= "z") return 26 + int'(c - "a");
    if (c >= "0" && c <= "9") return 52 + int'(c - "0");
    if (c == "+") return 62;
    if (c == "/") return 63;
    return NotInAlphabet;
  endfunction

  function automatic logic at_capacity();
    return full || emitted >= capacity;
  endfunction

  // a byte past the capacity is dropped and latches the full state
  function automatic void emit_byte(input logic [7:0] b);
    if (at_capacity()) begin
      full = 1'b1;
      return;
    end
    emitted = emitted + 24'd1;
    if (emitted >= capacity) full = 1'b1;
    run_bytes[run_len] = '{b, 1'b1, emitted, full, 1'b0};
    run_len++;
  endfunction

  function automatic void decode_item(input logic [7:0] c, input logic valid,
                                      input logic last);
    int v;
    run_len = 0;
    if (valid && !at_capacity()) begin
      v = sextet_of(c);
      if (v != NotInAlphabet) begin
        accum = accum | (24'(v) << (18 - 6 * sextets));
        if (sextets == 2'd3) begin
          emit_byte(accum[23:16]);
          emit_byte(accum[15:8]);
          emit_byte(accum[7:0]);
          accum   = '0;
          sextets = '0;
        end else begin
          sextets = sextets + 2'd1;
        end
      end
    end
    if (last) begin
      // leftover flush: 12 bits give one byte, 18 bits give two
      if (!at_capacity() && sextets >= 2'd2) begin
        emit_byte(accum[23:16]);
        if (sextets == 2'd3) emit_byte(accum[15:8]);
      end
      if (run_len > 0) begin
        run_bytes[run_len - 1].msg_done = 1'b1;
      end else begin
        run_bytes[0] = '{8'h00, 1'b0, emitted, at_capacity(), 1'b1};
        run_len = 1;
      end
      accum   = '0;
      sextets = '0;
      emitted = '0;
      full    = 1'b0;
    end
    for (int i = 0; i < run_len; i++) byte_q.push_back(run_bytes[i]);
  endfunction

  function automatic void note_mismatch(input string what, input dec_byte_t want,
                                        input dec_byte_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%t %s: expected byte=%02h valid=%0b count=%0d cap=%0b done=%0b",
               $realtime, what, want.data_byte, want.byte_valid, want.byte_count,
               want.cap_reached, want.msg_done);
      $display("%t %s: got      byte=%02h valid=%0b count=%0d cap=%0b done=%0b",
               $realtime, what, got.data_byte, got.byte_valid, got.byte_count,
               got.cap_reached, got.msg_done);
    end
  endfunction

  function automatic void check_byte(input dec_byte_t got);
    dec_byte_t want;
    if (byte_q.size() == 0) begin
      note_mismatch("unexpected item", '0, got);
      return;
    end
    want = byte_q.pop_front();
    if (got !== want) note_mismatch("wrong item", want, got);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity = 24'hFFFFFF;
      accum    = '0;
      sextets  = '0;
      emitted  = '0;
      full     = 1'b0;
      byte_q.delete();
    end else begin
      if (sym_tvalid_i && sym_tready_i) begin
        decode_item(sym_tdata_i, sym_tuser_i[0], sym_tlast_i);
      end
      if (byte_tvalid_i && byte_tready_i) begin
        check_byte('{byte_tdata_i[7:0], byte_tuser_i[0], byte_tdata_i[31:8],
                     byte_tdata_i[32], byte_tlast_i});
      end
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == CapAddr) begin
        capacity = pwdata_i[23:0];
      end
    end
    pending = byte_q.size();
  end

endmodule

>>> bench/tb_base64_stream_decoder.sv
// top of the base64 stream decoder testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module tb_base64_stream_decoder;

  // register address of output_capacity
  localparam logic [2:0] OutputCapacityAddr = 3'd0;
  // quiet cycles after the last expected item, covers the front queue and pipeline
  localparam int DrainCycles = 24;
  localparam int CycleLimit  = 500000;
  localparam int RandomItems = 100;

  logic        clk_i;
  logic        rst_ni;
  logic [7:0]  s_axis_tdata;   // symbol
  logic [0:0]  s_axis_tuser;   // symbol_valid
  logic        s_axis_tlast;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] m_axis_tdata;   // data_byte, byte_count, capacity_reached, zero fill
  logic [0:0]  m_axis_tuser;   // byte_valid
  logic        m_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int   mismatches;
  int   pending_bytes;
  int   cycle_count = 0;
  int   items_sent = 0;   // items with a symbol or an end marker
  logic calm = 1'b1;      // no gaps on either side while set

  base64_stream_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  b64d_checker #(
    .CapAddr (OutputCapacityAddr)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .sym_tdata_i      (s_axis_tdata),
    .sym_tuser_i      (s_axis_tuser),
    .sym_tlast_i      (s_axis_tlast),
    .sym_tvalid_i     (s_axis_tvalid),
    .sym_tready_i     (s_axis_tready),
    .byte_tdata_i     (m_axis_tdata),
    .byte_tuser_i     (m_axis_tuser),
    .byte_tlast_i     (m_axis_tlast),
    .byte_tvalid_i    (m_axis_tvalid),
    .byte_tready_i    (m_axis_tready),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .pready_i         (pready),
    .mismatch_count_o (mismatches),
    .pending_count_o  (pending_bytes)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // hard stop in case the decoder hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // mostly no gap, some short ones, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // output side: random stalls, none while calm
  initial begin : byte_sink
    int stall;
    int r;
    stall = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
        r = $urandom_range(0, 99);
        if (!calm && r < 20) stall = $urandom_range(1, 3);
        else if (!calm && r < 24) stall = $urandom_range(10, 30);
      end
    end
  end

  function automatic logic [7:0] b64_char(input logic [5:0] idx);
    if (idx < 6'd26) return "A" + 8'(idx);
    if (idx < 6'd52) return "a" + 8'(idx - 6'd26);
    if (idx < 6'd62) return "0" + 8'(idx - 6'd52);
    if (idx == 6'd62) return "+";
    return "/";
  endfunction

  // caller sits at a falling edge; returns at the falling edge after acceptance
  // with tvalid still high, so a following item goes out back to back
  task automatic send_item(input logic [7:0] sym, input logic valid, input logic last);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'($urandom_range(0, 255));
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  <= sym;
    s_axis_tuser  <= valid;
    s_axis_tlast  <= last;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    if (valid || last) items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s, input logic close);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b1, close && i == s.len() - 1);
  endtask

  // wait until every expected item is out and the front queue has emptied
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_bytes != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_capacity(input logic [23:0] cap);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= OutputCapacityAddr;
    pwdata  <= {8'h00, cap};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [23:0] pick_capacity();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return 24'hFFFFFF;
    if (r == 2) return 24'd1;
    if (r == 3) return 24'($urandom_range(1, 24'hFFFFFF));
    return 24'($urandom_range(2, 12));
  endfunction

  // mostly well-formed text, with noise, padding, idle items and mid-message
  // capacity changes mixed in
  task automatic send_message();
    int   len;
    int   roll;
    int   k;
    logic bare_end;
    logic closes;
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 12);
    bare_end = ($urandom_range(0, 4) == 0);
    for (k = 0; k < len; k++) begin
      closes = !bare_end && (k == len - 1);
      roll = $urandom_range(0, 99);
      // idle item, causes nothing
      if (roll < 5) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      // capacity change with a message open, may land below the bytes already out
      if (roll >= 96 && !closes) begin
        settle();
        write_capacity(pick_capacity());
      end
      if (roll < 10) send_item(8'($urandom_range(0, 255)), 1'b1, closes);
      else if (roll < 14) send_item("=", 1'b1, closes);
      else send_item(b64_char(6'($urandom_range(0, 63))), 1'b1, closes);
    end
    if (bare_end) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  initial begin : stimulus
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    s_axis_tlast  = 1'b0;
    s_axis_tvalid = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    rst_ni        = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // full group from the alphabet edges, then 12 leftover bits and padding
    send_text("/+z9A0==", 1'b1);
    // noise bytes skipped, 18 leftover bits give two bytes
    send_item("A", 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item("B", 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item("C", 1'b1, 1'b1);
    // single sextet gives nothing, bare end marker closes with no byte
    send_item("Q", 1'b1, 1'b0);
    send_item(8'hA5, 1'b0, 1'b1);
    // idle item
    send_item(8'h5A, 1'b0, 1'b0);
    // capacity of one: only the first byte of the group leaves, flagged full
    settle();
    write_capacity(24'd1);
    send_text("TWFu", 1'b1);
    // capacity lowered below the bytes already out in an open message
    settle();
    write_capacity(24'hFFFFFF);
    send_text("TWFuT", 1'b0);
    settle();
    write_capacity(24'd2);
    send_text("W", 1'b1);

    items_sent = 0;
    while (items_sent < RandomItems) begin
      calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) == 0) begin
        settle();
        write_capacity(pick_capacity());
      end
      send_message();
    end

    calm = 1'b0;
    s_axis_tvalid <= 1'b0;
    while (pending_bytes != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (mismatches == 0 && pending_bytes == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
